// ----- rtl/mei_pkg.sv -----
// shared types, constants and codes for the escape-time iterator
`timescale 1ns / 1ps

package mei_pkg;

  // coordinate format: signed, four integer bits including sign
  localparam int COORD_W  = 32;
  localparam int FRAC_W   = COORD_W - 4;
  // threshold format: unsigned Q4.28
  localparam int THR_W    = 32;
  localparam int THR_FRAC = 28;

  localparam int LIMIT_W        = 16;
  localparam int ITER_WIDTH_DEF = 16;
  localparam int QUOT_W         = 16;
  localparam int FRACTION_W     = 17;
  localparam int STEP_W         = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

  localparam logic [LIMIT_W-1:0]    RST_LIMIT    = 16'd100;
  localparam logic [THR_W-1:0]      RST_THRESH   = 32'h4000_0000;
  localparam logic [FRACTION_W-1:0] ONE_FRACTION = 17'h1_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [FRACTION_W-1:0] escape_fraction;
    logic [STEP_W-1:0]     escape_step;
    logic                  escaped;
  } out_item_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_UPD  = 8'b0000_0010,
    ST_MXX  = 8'b0000_0100,
    ST_MYY  = 8'b0000_1000,
    ST_MXY  = 8'b0001_0000,
    ST_CHK  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic load;
    logic upd;
    logic mul_xx;
    logic mul_yy;
    logic mul_xy;
  } dp_ctrl_t;

  typedef struct packed {
    logic range_esc;
    logic thr_esc;
  } dp_stat_t;

endpackage

// ----- rtl/mei_dp.sv -----
// z datapath: one shared multiplier, z update and magnitude test
`timescale 1ns / 1ps

module mei_dp (
  input  logic                   clk_i,
  input  mei_pkg::dp_ctrl_t      ctrl_i,
  input  mei_pkg::in_item_t      in_data_i,
  input  logic [mei_pkg::THR_W-1:0] thresh_i,
  output mei_pkg::dp_stat_t      stat_o
);

  localparam int W  = mei_pkg::COORD_W;
  localparam int F  = mei_pkg::FRAC_W;
  localparam int ZW = W - 1;
  localparam int MW = W - 2;
  localparam int PW = 2 * MW;
  localparam int SW = PW + 3;
  localparam int TS = (2 * F >= mei_pkg::THR_FRAC) ? 2 * F - mei_pkg::THR_FRAC : 0;
  localparam int SS = (2 * F <  mei_pkg::THR_FRAC) ? mei_pkg::THR_FRAC - 2 * F : 0;
  localparam int CW = (PW + 1 + SS > mei_pkg::THR_W + TS) ? PW + 1 + SS
                                                          : mei_pkg::THR_W + TS;
  localparam logic [ZW-1:0] Z_MIN = {1'b1, {(ZW-1){1'b0}}};

  logic signed [W-1:0]  cr_q, ci_q;
  logic signed [ZW-1:0] x_q, y_q;
  logic [PW-1:0]        xx_q, yy_q, xy_q;
  logic                 xyn_q;

  logic [ZW-1:0] x_neg, y_neg;
  logic [MW-1:0] x_mag, y_mag, op_a, op_b;
  logic [PW-1:0] prod;

  logic signed [SW-1:0] diff, diff_sh, xy2, xy2_sh, re_full, im_full;
  logic [PW:0]          mag2;
  logic [CW-1:0]        lhs, rhs;

  // component leaves the |z| < 4 box, including exactly -4
  function automatic logic out_of_range(input logic signed [SW-1:0] v);
    logic [SW-ZW:0] hi;
    hi = v[SW-1:ZW-1];
    return !((hi == '0) || (hi == '1)) || (v[ZW-1:0] == Z_MIN);
  endfunction

  assign x_neg = -x_q;
  assign y_neg = -y_q;
  assign x_mag = x_q[ZW-1] ? x_neg[MW-1:0] : x_q[MW-1:0];
  assign y_mag = y_q[ZW-1] ? y_neg[MW-1:0] : y_q[MW-1:0];

  // operand select for the shared multiplier
  assign op_a = ctrl_i.mul_yy ? y_mag : x_mag;
  assign op_b = ctrl_i.mul_xx ? x_mag : y_mag;
  assign prod = op_a * op_b;

  // floor shift is an arithmetic right shift in two's complement
  assign diff    = $signed({3'b000, xx_q}) - $signed({3'b000, yy_q});
  assign xy2     = xyn_q ? -$signed({2'b00, xy_q, 1'b0}) : $signed({2'b00, xy_q, 1'b0});
  assign diff_sh = diff >>> F;
  assign xy2_sh  = xy2 >>> F;
  assign re_full = diff_sh + SW'(cr_q);
  assign im_full = xy2_sh + SW'(ci_q);

  assign mag2 = {1'b0, xx_q} + {1'b0, yy_q};
  assign lhs  = CW'(mag2) << SS;
  assign rhs  = CW'(thresh_i) << TS;

  assign stat_o.range_esc = out_of_range(re_full) || out_of_range(im_full);
  assign stat_o.thr_esc   = (lhs >= rhs);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cr_q  <= in_data_i.c_real;
      ci_q  <= in_data_i.c_imag;
      x_q   <= '0;
      y_q   <= '0;
      xx_q  <= '0;
      yy_q  <= '0;
      xy_q  <= '0;
      xyn_q <= 1'b0;
    end
    if (ctrl_i.upd) begin
      x_q <= re_full[ZW-1:0];
      y_q <= im_full[ZW-1:0];
    end
    if (ctrl_i.mul_xx) begin
      xx_q <= prod;
    end
    if (ctrl_i.mul_yy) begin
      yy_q <= prod;
    end
    if (ctrl_i.mul_xy) begin
      xy_q  <= prod;
      xyn_q <= x_q[ZW-1] ^ y_q[ZW-1];
    end
  end

endmodule

// ----- rtl/mei_div.sv -----
// restoring divider, one quotient bit per cycle, for the escape fraction
`timescale 1ns / 1ps

module mei_div #(
  parameter int DIV_W = mei_pkg::LIMIT_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIV_W-1:0]          dividend_i,
  input  logic [DIV_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic [mei_pkg::QUOT_W-1:0] quot_o
);

  localparam int QW    = mei_pkg::QUOT_W;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W:0]   rem_q, rem_dbl, rem_sub;
  logic [QW-1:0]    quot_q;
  logic             fits;

  // remainder stays below the divisor, so doubling never overflows
  assign rem_dbl = {rem_q[DIV_W-1:0], 1'b0};
  assign rem_sub = rem_dbl - {1'b0, divisor_i};
  assign fits    = (rem_dbl >= {1'b0, divisor_i});

  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i};
    end else if (busy_q) begin
      rem_q  <= fits ? rem_sub : rem_dbl;
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

endmodule

// ----- rtl/mandelbrot_escape_iterator_unit.sv -----
// top level: sequencer, config registers and result register
`timescale 1ns / 1ps

// escape-time iterator for one complex point c = c_real + j*c_imag (signed Q3.28)
// input channel: in_valid_i / in_stall_o, item taken when valid and not stall
// output channel: out_valid_o / out_stall_i, one result item per input item
// config: cfg_we_i writes iteration_limit (index 0) or escape_threshold (index 1);
//   write only while no item is in flight
// each step z = z*z + c runs through update, three products on the one
//   shared multiplier (x*x, y*y, x*y), then the |z|^2 threshold test
// a zero limit skips the steps, and a point that never escapes stops after limit steps;
//   when |z|^2 meets the bound or a component reaches 4.0, the bit-serial fraction
//   divide runs before the result is formed; the result may then wait for the output
//   register
// throughput: one item at a time, in_stall_o is high from acceptance until the
//   result is moved into the output register
// the output register frees the sequencer: a new item can be taken while the
//   previous result still waits under out_stall_i
// reset: limit 100, threshold 4.0, sequencer idle, output register empty

module mandelbrot_escape_iterator_unit #(
  parameter int ITER_WIDTH = mei_pkg::ITER_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mei_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mei_pkg::out_item_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [mei_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mei_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  // limit register is at most 16 bits, narrowed further by a narrower ITER_WIDTH
  localparam int LW = (ITER_WIDTH < mei_pkg::LIMIT_W) ? ITER_WIDTH : mei_pkg::LIMIT_W;
  localparam int KW = LW + 1;

  mei_pkg::state_e   state_q, state_d;
  logic [LW-1:0]     k_q, k_d;
  logic              esc_q, esc_d;
  logic [LW-1:0]     limit_q;
  logic [mei_pkg::THR_W-1:0] thresh_q;

  mei_pkg::out_item_t out_q;
  logic               out_valid_q, out_valid_d, out_load;

  mei_pkg::dp_ctrl_t  dp_ctrl;
  mei_pkg::dp_stat_t  dp_stat;

  logic                        div_start, div_done;
  logic [mei_pkg::QUOT_W-1:0]  div_quot;
  logic                        k_last;

  // ---------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= mei_pkg::RST_LIMIT[LW-1:0];
      thresh_q <= mei_pkg::RST_THRESH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mei_pkg::REG_LIMIT:  limit_q  <= cfg_wdata_i[LW-1:0];
        mei_pkg::REG_THRESH: thresh_q <= cfg_wdata_i[mei_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // shared datapath and fraction divider
  // ---------------------------------------------------------------------
  mei_dp u_dp (
    .clk_i     (clk_i),
    .ctrl_i    (dp_ctrl),
    .in_data_i (in_data_i),
    .thresh_i  (thresh_q),
    .stat_o    (dp_stat)
  );

  // fraction = floor(k * 2^16 / limit), k always below limit here
  mei_div #(
    .DIV_W (LW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (k_q),
    .divisor_i  (limit_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  assign k_last     = (({1'b0, k_q} + KW'(1)) == {1'b0, limit_q});
  assign in_stall_o = (state_q != mei_pkg::ST_IDLE);

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    esc_d     = esc_q;
    dp_ctrl   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      mei_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          dp_ctrl.load = 1'b1;
          k_d          = '0;
          esc_d        = 1'b0;
          // zero limit: no step, report as never escaping
          state_d      = (limit_q == '0) ? mei_pkg::ST_FIN : mei_pkg::ST_UPD;
        end
      end
      mei_pkg::ST_UPD: begin
        dp_ctrl.upd = 1'b1;
        if (dp_stat.range_esc) begin
          // a component at or beyond 4.0 always meets the bound
          esc_d     = 1'b1;
          div_start = 1'b1;
          state_d   = mei_pkg::ST_DIV;
        end else begin
          state_d = mei_pkg::ST_MXX;
        end
      end
      mei_pkg::ST_MXX: begin
        dp_ctrl.mul_xx = 1'b1;
        state_d        = mei_pkg::ST_MYY;
      end
      mei_pkg::ST_MYY: begin
        dp_ctrl.mul_yy = 1'b1;
        state_d        = mei_pkg::ST_MXY;
      end
      mei_pkg::ST_MXY: begin
        dp_ctrl.mul_xy = 1'b1;
        state_d        = mei_pkg::ST_CHK;
      end
      mei_pkg::ST_CHK: begin
        // x*x and y*y of the new z serve both the test and the next step
        if (dp_stat.thr_esc) begin
          esc_d     = 1'b1;
          div_start = 1'b1;
          state_d   = mei_pkg::ST_DIV;
        end else if (k_last) begin
          state_d = mei_pkg::ST_FIN;
        end else begin
          k_d     = k_q + LW'(1);
          state_d = mei_pkg::ST_UPD;
        end
      end
      mei_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = mei_pkg::ST_FIN;
        end
      end
      mei_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = mei_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mei_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mei_pkg::ST_IDLE;
      k_q     <= '0;
      esc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      esc_q   <= esc_d;
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.escaped         <= esc_q;
      out_q.escape_step     <= esc_q ? mei_pkg::STEP_W'(k_q) : '0;
      out_q.escape_fraction <= esc_q ? {1'b0, div_quot} : mei_pkg::ONE_FRACTION;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_no_escape_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.escaped) |->
      (out_data_o.escape_fraction == mei_pkg::ONE_FRACTION &&
       out_data_o.escape_step == '0))
    else $error("non-escaped result carries a step or fraction");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=>
      (state_q == mei_pkg::ST_UPD || state_q == mei_pkg::ST_FIN))
    else $error("accepted item did not start iterating");

  a_step_held_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mei_pkg::ST_DIV) |-> $stable(k_q))
    else $error("step count changed during fraction divide");

endmodule
